// File: sv/confusion_matrix_class_metrics_assert.svh
// ----------------------------------------------------------------------------
// confusion matrix metrics assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_CLASS_METRICS_ASSERT_SVH
`define CONFUSION_MATRIX_CLASS_METRICS_ASSERT_SVH

// same-cycle implication
`define CMCM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CMCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/cmcm_pkg.sv
// ----------------------------------------------------------------------------
// cmcm_pkg
// types, constants and helpers of the confusion matrix metrics block
// ----------------------------------------------------------------------------
package cmcm_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int CLASS_LIM   = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
   localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int COUNT_W     = 32;
   localparam int SUM_W       = 36;
   localparam int NUM_W       = 33;
   localparam int DEN_W       = 38;
   localparam int Q_W         = 17;
   localparam int CNT_W       = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REPORT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [CNT_W-1:0] CLASS_COUNT_RST = 5'd10;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] actual_class;
      logic [3:0] predicted_class;
   } req_word_type;

   typedef struct packed {
      logic [3:0]         class_index;
      logic [Q_W-1:0]     precision_q16;
      logic [Q_W-1:0]     recall_q16;
      logic [Q_W-1:0]     f1_q16;
      logic [SUM_W-1:0]   support;
      logic [COUNT_W-1:0] cell_value;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [COUNT_W-1:0] wr_data;
   } store_req_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quot;
   } div_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
      cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_CLASSES) + ADDR_W'(col));
   endfunction

   function automatic logic [CNT_W-1:0] classes_in_use(input logic [CNT_W-1:0] cc);
      if (cc == '0) begin
         classes_in_use = CNT_W'(1);
      end else if (cc > CNT_W'(CLASS_LIM)) begin
         classes_in_use = CNT_W'(CLASS_LIM);
      end else begin
         classes_in_use = cc;
      end
   endfunction

endpackage

// File: sv/cmcm_store.sv
// ----------------------------------------------------------------------------
// cmcm_store
// count memory, one read and one write port, registered read, cleared by
// per-entry valid bits
// ----------------------------------------------------------------------------
module cmcm_store (
   input  logic                            clock,
   input  logic                            reset,
   input  cmcm_pkg::store_req_type         store_req,
   output logic [cmcm_pkg::COUNT_W-1:0]    rd_data
);
   import cmcm_pkg::*;

   logic [COUNT_W-1:0] mem [CELLS];
   logic [CELLS-1:0]   valid_ff;
   logic [COUNT_W-1:0] data_ff;
   logic               vld_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         data_ff <= mem[store_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            valid_ff[store_req.wr_addr] <= 1'b1;
         end
         if (store_req.rd_en) begin
            vld_ff <= valid_ff[store_req.rd_addr];
         end
      end
   end

   assign rd_data = vld_ff ? data_ff : '0;

endmodule

// File: sv/cmcm_div.sv
// ----------------------------------------------------------------------------
// cmcm_div
// restoring divider for q16 ratios, numerator never above denominator,
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module cmcm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cmcm_pkg::div_req_type div_req,
   output cmcm_pkg::div_rsp_type div_rsp
);
   import cmcm_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W:0]     rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [Q_W-1:0]     quot_ff;
   logic               zero_ff;
   logic [DEN_W:0]     shift_in;
   logic               fit_in;
   logic               ge_in;

   assign shift_in = {rem_ff[DEN_W-1:0], 1'b0};
   assign fit_in   = shift_in >= {1'b0, den_ff};
   assign ge_in    = DEN_W'(div_req.num) >= div_req.den;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(Q_W - 1);
            den_ff  <= div_req.den;
            zero_ff <= div_req.den == '0;
            rem_ff  <= ge_in ? '0 : (DEN_W + 1)'(div_req.num);
            quot_ff <= Q_W'(ge_in);
         end else if (busy_ff) begin
            rem_ff  <= fit_in ? shift_in - {1'b0, den_ff} : shift_in;
            quot_ff <= {quot_ff[Q_W-2:0], fit_in};
            cnt_ff  <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = zero_ff ? '0 : quot_ff;

endmodule

// File: sv/confusion_matrix_class_metrics.sv
// ----------------------------------------------------------------------------
// confusion_matrix_class_metrics
// confusion matrix accumulator with per-class precision, recall and f1
// ----------------------------------------------------------------------------
// Counts sit in one memory of MAX_CLASSES squared 32-bit cells with one read
// and one write port and a registered read. An add word is a read then a
// saturating write back, with no write when a class is out of range. An
// unused command is dropped. A read word is a registered read that waits in
// S_READ through any output stall. A report word walks the memory per class,
// one row cell and one column cell per class in use in S_ROW, S_ROWD and
// S_COLD, then runs three serial divisions for precision, recall and f1 and
// waits in S_EMIT through any output stall. The result register lets the
// next word be taken while the last result waits. Reset clears the counts at once.
// ----------------------------------------------------------------------------
module confusion_matrix_class_metrics (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cmcm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cmcm_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic [4:0]             csr_wr_data
);
   import cmcm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_READ, S_ROW, S_ROWD, S_COLD, S_DIV_P, S_DIV_R, S_DIV_F, S_EMIT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   class_count_ff;
   logic [CNT_W-1:0]   n_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic               ok_ff;
   logic [CNT_W-1:0]   cls_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [COUNT_W-1:0] tp_ff;
   logic [SUM_W-1:0]   fp_ff;
   logic [SUM_W-1:0]   fn_ff;
   logic [Q_W-1:0]     prec_ff;
   logic [Q_W-1:0]     rec_ff;
   logic [Q_W-1:0]     f1_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   div_req_type        div_req_ff;
   div_rsp_type        div_rsp;
   store_req_type      store_req;
   logic [COUNT_W-1:0] rd_data;
   logic [SUM_W-1:0]   fp_in;
   logic               accept;
   logic               req_ok;
   logic               out_free;

   assign n_in      = classes_in_use(class_count_ff);
   assign accept    = req_valid && !req_stall;
   assign req_ok    = (CNT_W'(req_word.actual_class) < n_in)
                   && (CNT_W'(req_word.predicted_class) < n_in);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign fp_in     = (idx_ff != cls_ff) ? fp_ff + SUM_W'(rd_data) : fp_ff;

   always_comb begin
      store_req         = '0;
      store_req.wr_addr = addr_ff;
      store_req.wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_W'(1);
      unique case (state_ff)
         S_IDLE: begin
            store_req.rd_en   = accept;
            store_req.rd_addr = cell_addr(CNT_W'(req_word.actual_class),
                                          CNT_W'(req_word.predicted_class));
         end
         S_ADD:  store_req.wr_en = 1'b1;
         S_ROW: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = cell_addr(cls_ff, idx_ff);
         end
         S_ROWD: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = cell_addr(idx_ff, cls_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         class_count_ff   <= CLASS_COUNT_RST;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         if (csr_wr_en) begin
            class_count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  addr_ff <= store_req.rd_addr;
                  ok_ff   <= req_ok;
                  cls_ff  <= '0;
                  idx_ff  <= '0;
                  tp_ff   <= '0;
                  fp_ff   <= '0;
                  fn_ff   <= '0;
                  priority if (req_word.cmd == CMD_ADD && req_ok) begin
                     state_ff <= S_ADD;
                  end else if (req_word.cmd == CMD_READ) begin
                     state_ff <= S_READ;
                  end else if (req_word.cmd == CMD_REPORT) begin
                     state_ff <= S_ROW;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_ADD: state_ff <= S_IDLE;
            S_READ: begin
               if (out_free) begin
                  rsp_word_ff.class_index   <= '0;
                  rsp_word_ff.precision_q16 <= '0;
                  rsp_word_ff.recall_q16    <= '0;
                  rsp_word_ff.f1_q16        <= '0;
                  rsp_word_ff.support       <= '0;
                  rsp_word_ff.cell_value    <= ok_ff ? rd_data : '0;
                  rsp_word_ff.last          <= 1'b1;
                  rsp_valid_ff              <= 1'b1;
                  state_ff                  <= S_IDLE;
               end
            end
            S_ROW: state_ff <= S_ROWD;
            S_ROWD: begin
               if (idx_ff == cls_ff) begin
                  tp_ff <= rd_data;
               end else begin
                  fn_ff <= fn_ff + SUM_W'(rd_data);
               end
               state_ff <= S_COLD;
            end
            S_COLD: begin
               fp_ff <= fp_in;
               if (idx_ff + CNT_W'(1) == n_in) begin
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= NUM_W'(tp_ff);
                  div_req_ff.den   <= DEN_W'(tp_ff) + DEN_W'(fp_in);
                  state_ff         <= S_DIV_P;
               end else begin
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= S_ROW;
               end
            end
            S_DIV_P: begin
               if (div_rsp.done) begin
                  prec_ff          <= div_rsp.quot;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= NUM_W'(tp_ff);
                  div_req_ff.den   <= DEN_W'(tp_ff) + DEN_W'(fn_ff);
                  state_ff         <= S_DIV_R;
               end
            end
            S_DIV_R: begin
               if (div_rsp.done) begin
                  rec_ff           <= div_rsp.quot;
                  div_req_ff.start <= 1'b1;
                  div_req_ff.num   <= {tp_ff, 1'b0};
                  div_req_ff.den   <= DEN_W'({tp_ff, 1'b0}) + DEN_W'(fp_ff)
                                    + DEN_W'(fn_ff);
                  state_ff         <= S_DIV_F;
               end
            end
            S_DIV_F: begin
               if (div_rsp.done) begin
                  f1_ff    <= div_rsp.quot;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_word_ff.class_index   <= cls_ff[3:0];
                  rsp_word_ff.precision_q16 <= prec_ff;
                  rsp_word_ff.recall_q16    <= rec_ff;
                  rsp_word_ff.f1_q16        <= f1_ff;
                  rsp_word_ff.support       <= SUM_W'(tp_ff) + fn_ff;
                  rsp_word_ff.cell_value    <= '0;
                  rsp_word_ff.last          <= cls_ff + CNT_W'(1) == n_in;
                  rsp_valid_ff              <= 1'b1;
                  idx_ff                    <= '0;
                  tp_ff                     <= '0;
                  fp_ff                     <= '0;
                  fn_ff                     <= '0;
                  cls_ff                    <= cls_ff + CNT_W'(1);
                  state_ff <= (cls_ff + CNT_W'(1) == n_in) ? S_IDLE : S_ROW;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   cmcm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   cmcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

`include "confusion_matrix_class_metrics_assert.svh"

   `CMCM_ASSERT_NEXT(a_read_blocks, clock, reset, accept && req_word.cmd == CMD_READ, req_stall)
   `CMCM_ASSERT_NOW(a_cell_last, clock, reset, rsp_valid && rsp_word.cell_value != '0, rsp_word.last)
   `CMCM_ASSERT_NOW(a_f1_range, clock, reset, rsp_valid && rsp_word.f1_q16[Q_W-1], rsp_word.f1_q16[Q_W-2:0] == '0)

endmodule
